// ===== sv/sobel_aeb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the adaptive Sobel edge binarizer.
// No dependencies; imported by every module of the block but sobel_aeb_ram.
package sobel_aeb_pkg;

   localparam int IMAGE_WIDTH  = 160;
   localparam int IMAGE_HEIGHT = 120;

   localparam int PIX_W     = 8;
   localparam int COL_W     = $clog2(IMAGE_WIDTH);
   localparam int ROW_W     = $clog2(IMAGE_HEIGHT);
   localparam int ROW_OUT_W = 7;
   localparam int COL_OUT_W = 8;
   localparam int GRAD_W    = 11;
   localparam int BRIGHT_W  = 12;
   localparam int MAG12_W   = 15;
   localparam int LINE_W    = 2 * PIX_W;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic signed [GRAD_W-1:0]    gx;
      logic signed [GRAD_W-1:0]    gy;
      logic        [BRIGHT_W-1:0]  bright;
      logic        [ROW_OUT_W-1:0] row;
      logic        [COL_OUT_W-1:0] col;
      logic                        last;
   } sums_type;

endpackage

// ===== sv/sobel_aeb_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module sobel_aeb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sobel_aeb_window.sv =====
`timescale 1ns / 1ps
// Position counters, line buffer access with forwarding and the 3x3 window.
// Forms Sobel gradients and weighted brightness; uses sobel_aeb_pkg, sobel_aeb_ram.
module sobel_aeb_window (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [sobel_aeb_pkg::PIX_W-1:0]     in_pixel,
   input  logic                                in_frame_start,
   output logic                                sums_valid,
   input  logic                                sums_ready,
   output sobel_aeb_pkg::sums_type             sums
);
   import sobel_aeb_pkg::*;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_eff;
   logic [COL_W-1:0]  col_eff;
   logic              accept;

   logic              s1_v_ff, s1_v_in;
   logic [PIX_W-1:0]  s1_px_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_prod;
   logic              s1_adv;

   logic              fwd_ff, fwd_in;
   logic [LINE_W-1:0] fwd_data_ff;

   logic              wr_en;
   logic [LINE_W-1:0] wr_data;
   logic [LINE_W-1:0] rd_data;
   logic [LINE_W-1:0] line;
   logic [PIX_W-1:0]  top, mid;

   logic [PIX_W-1:0]  win_ff [6];

   logic [PIX_W-1:0]  p00, p10, p20, p01, p11, p21, p02, p12, p22;

   assign row_eff = in_frame_start ? '0 : row_ff;
   assign col_eff = in_frame_start ? '0 : col_ff;
   assign accept  = in_valid && in_ready;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_eff == COL_W'(IMAGE_WIDTH - 1)) begin
            col_in = '0;
            row_in = (row_eff == ROW_W'(IMAGE_HEIGHT - 1)) ? '0 : row_eff + 1'b1;
         end else begin
            col_in = col_eff + 1'b1;
            row_in = row_eff;
         end
      end
   end

   assign s1_prod  = s1_v_ff && (s1_row_ff >= ROW_W'(2)) && (s1_col_ff >= COL_W'(2));
   assign s1_adv   = !s1_v_ff || !s1_prod || sums_ready;
   assign in_ready = s1_adv;
   assign s1_v_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_ff);

   assign wr_en   = s1_v_ff && s1_adv;
   assign line    = fwd_ff ? fwd_data_ff : rd_data;
   assign top     = line[PIX_W-1:0];
   assign mid     = line[LINE_W-1:PIX_W];
   assign wr_data = {s1_px_ff, mid};
   assign fwd_in  = wr_en && (col_eff == s1_col_ff);

   sobel_aeb_ram #(
      .WIDTH (LINE_W),
      .DEPTH (IMAGE_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col_eff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         s1_v_ff <= 1'b0;
         fwd_ff  <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         s1_v_ff <= s1_v_in;
         if (accept) begin
            fwd_ff <= fwd_in;
         end
         if (wr_en) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top;
            win_ff[4] <= mid;
            win_ff[5] <= s1_px_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff    <= in_pixel;
         s1_row_ff   <= row_eff;
         s1_col_ff   <= col_eff;
         fwd_data_ff <= wr_data;
      end
   end

   assign p00 = win_ff[0];
   assign p10 = win_ff[1];
   assign p20 = win_ff[2];
   assign p01 = win_ff[3];
   assign p11 = win_ff[4];
   assign p21 = win_ff[5];
   assign p02 = top;
   assign p12 = mid;
   assign p22 = s1_px_ff;

   always_comb begin
      sums.gx = GRAD_W'(p02) + GRAD_W'(p22) + (GRAD_W'(p12) << 1)
              - GRAD_W'(p00) - GRAD_W'(p20) - (GRAD_W'(p10) << 1);
      sums.gy = GRAD_W'(p20) + GRAD_W'(p22) + (GRAD_W'(p21) << 1)
              - GRAD_W'(p00) - GRAD_W'(p02) - (GRAD_W'(p01) << 1);
      sums.bright = BRIGHT_W'(p00) + BRIGHT_W'(p02) + BRIGHT_W'(p20) + BRIGHT_W'(p22)
                  + BRIGHT_W'(p11)
                  + ((BRIGHT_W'(p01) + BRIGHT_W'(p10) + BRIGHT_W'(p12) + BRIGHT_W'(p21)) << 1);
      sums.row  = ROW_OUT_W'(s1_row_ff - 1'b1);
      sums.col  = COL_OUT_W'(s1_col_ff - 1'b1);
      sums.last = (s1_row_ff == ROW_W'(IMAGE_HEIGHT - 1))
               && (s1_col_ff == COL_W'(IMAGE_WIDTH - 1));
   end

   assign sums_valid = s1_prod;

   a_fwd_follows_write: assert property (@(posedge clock) disable iff (reset)
      $rose(fwd_ff) |-> $past(wr_en))
      else $error("forward flag set without a line buffer write");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s1_adv |=> s1_v_ff && $stable(s1_col_ff) && $stable(s1_px_ff))
      else $error("stalled window stage lost its request");

endmodule

// ===== sv/sobel_aeb_judge.sv =====
`timescale 1ns / 1ps
// Gradient magnitude, adaptive threshold compare and output register.
// Depends on sobel_aeb_pkg.
module sobel_aeb_judge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 sums_valid,
   output logic                                 sums_ready,
   input  sobel_aeb_pkg::sums_type              sums,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic                                 out_edge,
   output logic [sobel_aeb_pkg::ROW_OUT_W-1:0]  out_row,
   output logic [sobel_aeb_pkg::COL_OUT_W-1:0]  out_col,
   output logic                                 out_last
);
   import sobel_aeb_pkg::*;

   logic                 s2_v_ff;
   sums_type             s2_ff;
   logic                 s2_adv;
   logic                 out_adv;

   logic [GRAD_W-2:0]    ax, ay;
   logic [GRAD_W-1:0]    mag;
   logic [MAG12_W-1:0]   mag12;
   logic                 is_edge;

   logic                 out_v_ff;
   logic                 edge_ff;
   logic [ROW_OUT_W-1:0] row_ff;
   logic [COL_OUT_W-1:0] col_ff;
   logic                 last_ff;

   assign out_adv    = !out_v_ff || out_ready;
   assign s2_adv     = !s2_v_ff || out_adv;
   assign sums_ready = s2_adv;

   assign ax      = s2_ff.gx[GRAD_W-1] ? (GRAD_W-1)'(-s2_ff.gx) : s2_ff.gx[GRAD_W-2:0];
   assign ay      = s2_ff.gy[GRAD_W-1] ? (GRAD_W-1)'(-s2_ff.gy) : s2_ff.gy[GRAD_W-2:0];
   assign mag     = GRAD_W'(ax) + GRAD_W'(ay);
   assign mag12   = (MAG12_W'(mag) << 3) + (MAG12_W'(mag) << 2);
   assign is_edge = mag12 > MAG12_W'(s2_ff.bright);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s2_adv) begin
            s2_v_ff <= sums_valid;
         end
         if (out_adv) begin
            out_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && sums_valid) begin
         s2_ff <= sums;
      end
      if (out_adv && s2_v_ff) begin
         edge_ff <= is_edge;
         row_ff  <= s2_ff.row;
         col_ff  <= s2_ff.col;
         last_ff <= s2_ff.last;
      end
   end

   assign out_valid = out_v_ff;
   assign out_edge  = edge_ff;
   assign out_row   = row_ff;
   assign out_col   = col_ff;
   assign out_last  = last_ff;

   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (row_ff != '0) && (col_ff != '0))
      else $error("result for a border pixel");

endmodule

// ===== sv/sobel_adaptive_edge_binarize.sv =====
`timescale 1ns / 1ps
// Top level of the streaming 3x3 Sobel edge binarizer with adaptive threshold.
// Depends on sobel_aeb_pkg, sobel_aeb_window, sobel_aeb_judge.
//
//   channel | dir | tdata                                        | tuser        | tlast
//   req     | in  | [7:0] pixel                                  | frame_start  | -
//   rsp     | out | [0] edge_res, [7:1] center_row, [15:8] col  | -            | frame_last
//
// One request per clock unless rsp stalls; results pass window, judge and output registers.
// The line buffers share one RAM, read on accept and written as the request leaves
// the window stage, with a forward path when two requests touch the same column back to back.
// Border pixels update the buffers but produce no response.
// Reset clears counters, window and pipeline; unwritten RAM contents never reach a response.
// A stalled rsp holds the pipeline and drops req_tready once all stages are full.
module sobel_adaptive_edge_binarize (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sobel_aeb_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] pixel
   input  logic                                  req_tuser,   // [0] frame_start
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sobel_aeb_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [0] edge_res, [7:1] center_row,
                                                              // [15:8] center_col
   output logic                                  rsp_tlast
);
   import sobel_aeb_pkg::*;

   logic                 sums_valid;
   logic                 sums_ready;
   sums_type             sums;
   logic                 edge_res;
   logic [ROW_OUT_W-1:0] center_row;
   logic [COL_OUT_W-1:0] center_col;

   sobel_aeb_window u_window (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_pixel       (req_tdata[PIX_W-1:0]),
      .in_frame_start (req_tuser),
      .sums_valid     (sums_valid),
      .sums_ready     (sums_ready),
      .sums           (sums)
   );

   sobel_aeb_judge u_judge (
      .clock      (clock),
      .reset      (reset),
      .sums_valid (sums_valid),
      .sums_ready (sums_ready),
      .sums       (sums),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_edge   (edge_res),
      .out_row    (center_row),
      .out_col    (center_col),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {center_col, center_row, edge_res};

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         (center_row == ROW_OUT_W'(IMAGE_HEIGHT - 2))
         && (center_col == COL_OUT_W'(IMAGE_WIDTH - 2)))
      else $error("frame_last on a pixel other than the last interior one");

endmodule
